>>> rtl/core/mkdt_pkg.sv
// Shared types and constants for the MAC-keyed device table.
package mkdt_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int ADDR_W    = 48;
    localparam int STR_W     = 8;
    localparam int TIME_W    = 32;
    localparam int OUT_IDX_W = 4;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_ADDED   = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // One entry's payload beside its address
    typedef struct packed {
        logic [STR_W-1:0]  strength;
        logic [TIME_W-1:0] last_seen;
        logic [TIME_W-1:0] previous_seen;
    } rec_t;

    // Memory access request from the sequencer to the store
    typedef struct packed {
        logic [IDX_W-1:0]  addr_rd_idx;
        logic [IDX_W-1:0]  rec_rd_idx;
        logic              addr_wr_en;
        logic              rec_wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [ADDR_W-1:0] wr_addr;
        rec_t              wr_rec;
    } mem_req_t;

endpackage

>>> rtl/core/mkdt_store.sv
// Entry storage: address memory and record memory, synchronous registered reads.
module mkdt_store (
    input  logic                       clk,
    input  mkdt_pkg::mem_req_t         req,
    output logic [mkdt_pkg::ADDR_W-1:0] rd_addr,
    output mkdt_pkg::rec_t             rd_rec
);
    import mkdt_pkg::*;

    logic [ADDR_W-1:0] addr_mem [ENTRIES];
    rec_t              rec_mem  [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.addr_wr_en)
        begin
            addr_mem[req.wr_idx] <= req.wr_addr;
        end
        rd_addr <= addr_mem[req.addr_rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (req.rec_wr_en)
        begin
            rec_mem[req.wr_idx] <= req.wr_rec;
        end
        rd_rec <= rec_mem[req.rec_rd_idx];
    end

endmodule

>>> rtl/core/mkdt_ctrl.sv
// Lookup sequencer: scans stored addresses, updates or appends, drives the result register.
module mkdt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mkdt_pkg::ADDR_W-1:0]  device_address,
    input  logic [mkdt_pkg::STR_W-1:0]   signal_strength,
    input  logic [mkdt_pkg::TIME_W-1:0]  now_ms,
    output logic                         out_valid,
    input  logic                         out_stall,
    output mkdt_pkg::status_t            status,
    output logic [mkdt_pkg::OUT_IDX_W-1:0] entry_index,
    output logic [mkdt_pkg::TIME_W-1:0]  since_previous_ms,
    output mkdt_pkg::mem_req_t           req,
    input  logic [mkdt_pkg::ADDR_W-1:0]  rd_addr,
    input  mkdt_pkg::rec_t               rd_rec
);
    import mkdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [ADDR_W-1:0] item_addr_reg;
    logic [STR_W-1:0]  item_str_reg;
    logic [TIME_W-1:0] item_now_reg;
    status_t           pend_status_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [TIME_W-1:0] pend_since_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    logic [OUT_IDX_W-1:0] entry_index_reg;
    logic [TIME_W-1:0] since_reg;

    logic in_xfer;
    logic out_free;
    logic addr_match;
    logic scan_last;
    logic table_full;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign addr_match = (rd_addr == item_addr_reg);
    assign scan_last  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg == CNT_W'(ENTRIES));

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign entry_index       = entry_index_reg;
    assign since_previous_ms = since_reg;

    always_comb
    begin
        req             = '0;
        req.rec_rd_idx  = scan_idx_reg;
        req.addr_rd_idx = (state_reg == S_SCAN) ? scan_idx_reg + IDX_W'(1) : '0;
        req.wr_addr     = item_addr_reg;
        req.wr_rec.strength  = item_str_reg;
        req.wr_rec.last_seen = item_now_reg;
        unique case (state_reg)
            S_HIT:
            begin
                req.rec_wr_en            = 1'b1;
                req.wr_idx               = scan_idx_reg;
                req.wr_rec.previous_seen = rd_rec.last_seen;
            end
            S_MISS:
            begin
                req.addr_wr_en           = !table_full;
                req.rec_wr_en            = !table_full;
                req.wr_idx               = IDX_W'(count_reg);
                req.wr_rec.previous_seen = '0;
            end
            default:
            begin
                req.wr_idx = scan_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // S_OUT drives the result valid itself
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        item_addr_reg <= device_address;
                        item_str_reg  <= signal_strength;
                        item_now_reg  <= now_ms;
                        scan_idx_reg  <= '0;
                        state_reg     <= (count_reg == '0) ? S_MISS : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // rd_addr holds the entry at scan_idx_reg
                    if (addr_match)
                    begin
                        state_reg <= S_HIT;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                S_HIT:
                begin
                    pend_status_reg <= ST_UPDATED;
                    pend_idx_reg    <= scan_idx_reg;
                    pend_since_reg  <= item_now_reg - rd_rec.last_seen;
                    state_reg       <= S_OUT;
                end
                S_MISS:
                begin
                    pend_since_reg <= '0;
                    if (table_full)
                    begin
                        pend_status_reg <= ST_FULL;
                        pend_idx_reg    <= '0;
                    end
                    else
                    begin
                        pend_status_reg <= ST_ADDED;
                        pend_idx_reg    <= IDX_W'(count_reg);
                        count_reg       <= count_reg + CNT_W'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= pend_status_reg;
                        entry_index_reg <= OUT_IDX_W'(pend_idx_reg);
                        since_reg       <= pend_since_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/mac_keyed_device_table_core.sv
// Result follows the scan of stored entries: a hit goes SCAN, HIT, OUT; a miss goes SCAN, MISS, OUT;
// an empty table goes straight to MISS, then OUT; a stalled earlier result holds OUT until it drains.
// Throughput: one item at a time; the address memory's single read port,
// one word per cycle, sets the scan length.
// Reset (rst_n, async, active low) clears entry count, sequencer state and result valid;
// memory contents are left as they are and never used before being written.
module mac_keyed_device_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel: one advertisement per transfer
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mkdt_pkg::ADDR_W-1:0]    device_address,
    input  logic [mkdt_pkg::STR_W-1:0]     signal_strength,
    input  logic [mkdt_pkg::TIME_W-1:0]    now_ms,
    // output channel: one result per accepted advertisement
    output logic                           out_valid,
    input  logic                           out_stall,
    output mkdt_pkg::status_t              status,
    output logic [mkdt_pkg::OUT_IDX_W-1:0] entry_index,
    output logic [mkdt_pkg::TIME_W-1:0]    since_previous_ms
);
    import mkdt_pkg::*;

    // Sequencer to memory requests and the registered read data back
    mem_req_t          req;
    logic [ADDR_W-1:0] rd_addr;
    rec_t              rd_rec;

    // Sequencer: reads one stored address per cycle, compares it against the
    // incoming address, then either rewrites the hit record (old last time
    // becomes previous time) or appends a new entry when room is left.
    // The result register decouples the output side, so a new transfer is
    // taken while an earlier result still waits downstream.
    mkdt_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .device_address    (device_address),
        .signal_strength   (signal_strength),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .entry_index       (entry_index),
        .since_previous_ms (since_previous_ms),
        .req               (req),
        .rd_addr           (rd_addr),
        .rd_rec            (rd_rec)
    );

    // Entry memories: addresses in one array, strength and times in another.
    // Writes are issued in HIT or MISS, before OUT, so they land before the next item's first read.
    mkdt_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec)
    );

endmodule

>>> rtl/core/mkdt_checker.sv
// Port-level checker for the device table core, with its bind.
module mkdt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [mkdt_pkg::ADDR_W-1:0]    device_address,
    input logic [mkdt_pkg::STR_W-1:0]     signal_strength,
    input logic [mkdt_pkg::TIME_W-1:0]    now_ms,
    input logic                           out_valid,
    input logic                           out_stall,
    input mkdt_pkg::status_t              status,
    input logic [mkdt_pkg::OUT_IDX_W-1:0] entry_index,
    input logic [mkdt_pkg::TIME_W-1:0]    since_previous_ms
);
    import mkdt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(entry_index) && $stable(since_previous_ms))
        else $error("stalled result changed");

    // one item in flight: busy right after an input transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous item in work");

    // dropped item reports index 0 and no elapsed time
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (entry_index == '0) && (since_previous_ms == '0))
        else $error("dropped item with nonzero index or time");

    // new entry has no previous reception
    a_added_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ADDED) |-> (since_previous_ms == '0))
        else $error("new entry with nonzero elapsed time");

endmodule

bind mac_keyed_device_table_core mkdt_checker u_mkdt_checker (.*);
